### hdl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, register codes and pipeline side-band types of the
// UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int unsigned MAX_FRAGMENTS_DEF = 255;

	// register reset values
	localparam logic [15:0] RADIUS_RST = 16'd256;
	localparam logic [7:0]  COLS_RST   = 8'd16;
	localparam logic [7:0]  ROWS_RST   = 8'd16;

	// register index on the configuration port
	typedef enum logic [1:0] {
		REG_RADIUS = 2'd0,
		REG_COLS   = 2'd1,
		REG_ROWS   = 2'd2
	} reg_idx_t;

	localparam int unsigned APB_AW = 4;

	// quotient bits of the divider, enough for a full turn of 2^18 plus one
	localparam int unsigned DIV_QW = 19;

	// numerator shifts: full turn, half turn, texture fraction
	localparam int unsigned SH_FULL = 18;
	localparam int unsigned SH_HALF = 17;
	localparam int unsigned SH_TEX  = 16;

	localparam int unsigned QUARTER_TURN = 65536;

	// sine polynomial coefficients, Q30
	localparam logic [30:0] C9 = 31'd172272;
	localparam logic [30:0] HORNER_C [4] = '{
		31'd5026995,     // c7
		31'd85569305,    // c5
		31'd693598668,   // c3
		31'd1686629713   // c1
	};

	localparam int unsigned SIN_ROUND = 16384;
	localparam logic [15:0] SIN_MAX   = 16'd32768;

	// lanes of the divider and of the sine unit
	localparam int unsigned NLANE = 4;

	// side band carried along the divider
	typedef struct packed {
		logic        in_grid;
		logic        has_cell;
		logic [15:0] idx_tl;
		logic [15:0] idx_bl;
		logic [15:0] idx_br;
		logic [15:0] idx_tr;
	} grid_t;

	// side band carried along the sine unit and the scaling stages
	typedef struct packed {
		grid_t       grid;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic [3:0]  neg;    // sign of sin lon, cos lon, sin lat, cos lat
	} vtx_meta_t;

endpackage

### hdl/uvs_point_if.sv
// ----------------------------------------------------------------------------
// uvs_point_if
// Grid point channel: valid/ready with column and row.
// ----------------------------------------------------------------------------
interface uvs_point_if;
	logic       valid;
	logic       ready;
	logic [7:0] col;
	logic [7:0] row;

	modport source(output valid, output col, output row, input ready);
	modport sink(input valid, input col, input row, output ready);
endinterface

### hdl/uvs_vertex_if.sv
// ----------------------------------------------------------------------------
// uvs_vertex_if
// Vertex channel: valid/ready with position, texture and cell indices.
// ----------------------------------------------------------------------------
interface uvs_vertex_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pos_x;
	logic signed [16:0] pos_y;
	logic signed [16:0] pos_z;
	logic [16:0]        tex_u;
	logic [16:0]        tex_v;
	logic [15:0]        idx_top_left;
	logic [15:0]        idx_bottom_left;
	logic [15:0]        idx_bottom_right;
	logic [15:0]        idx_top_right;
	logic               has_cell;
	logic               in_grid;

	modport source(output valid, output pos_x, output pos_y, output pos_z,
		output tex_u, output tex_v, output idx_top_left, output idx_bottom_left,
		output idx_bottom_right, output idx_top_right, output has_cell,
		output in_grid, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z,
		input tex_u, input tex_v, input idx_top_left, input idx_bottom_left,
		input idx_bottom_right, input idx_top_right, input has_cell,
		input in_grid, output ready);
endinterface

### hdl/uvs_div.sv
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, several lanes, one quotient bit per stage.
// Numerator must stay below divisor * 2^QW.
// ----------------------------------------------------------------------------
module uvs_div #(
	parameter int unsigned NL = 4,
	parameter int unsigned DW = 8,
	parameter int unsigned QW = 19,
	parameter int unsigned TW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             vin,
	input  logic [DW+QW-1:0] num [NL],
	input  logic [DW-1:0]    den [NL],
	input  logic [TW-1:0]    tag_in,
	output logic             vout,
	output logic [QW-1:0]    quo [NL],
	output logic [TW-1:0]    tag_out
);

	logic          v_s   [QW];
	logic [TW-1:0] tag_s [QW];
	logic [DW-1:0] rem_s [QW][NL];
	logic [QW-1:0] quo_s [QW][NL];

	logic [DW-1:0] src_rem [QW][NL];
	logic [QW-1:0] src_quo [QW][NL];
	logic [DW-1:0] nxt_rem [QW][NL];
	logic [QW-1:0] nxt_quo [QW][NL];

	always_comb begin
		logic [DW:0] t;
		logic        ge;
		for (int l = 0; l < NL; l++) begin
			src_rem[0][l] = num[l][DW+QW-1:QW];
			src_quo[0][l] = num[l][QW-1:0];
		end
		for (int g = 1; g < QW; g++) begin
			for (int l = 0; l < NL; l++) begin
				src_rem[g][l] = rem_s[g-1][l];
				src_quo[g][l] = quo_s[g-1][l];
			end
		end
		// shift in the next numerator bit, the quotient bit fills from below
		for (int g = 0; g < QW; g++) begin
			for (int l = 0; l < NL; l++) begin
				t  = {src_rem[g][l], src_quo[g][l][QW-1]};
				ge = (t >= {1'b0, den[l]});
				nxt_rem[g][l] = ge ? DW'(t - {1'b0, den[l]}) : DW'(t);
				nxt_quo[g][l] = {src_quo[g][l][QW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < QW; g++) v_s[g] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= vin;
			for (int g = 1; g < QW; g++) v_s[g] <= v_s[g-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0] <= tag_in;
			for (int g = 1; g < QW; g++) tag_s[g] <= tag_s[g-1];
			for (int g = 0; g < QW; g++) begin
				for (int l = 0; l < NL; l++) begin
					rem_s[g][l] <= nxt_rem[g][l];
					quo_s[g][l] <= nxt_quo[g][l];
				end
			end
		end
	end

	assign vout    = v_s[QW-1];
	assign tag_out = tag_s[QW-1];
	always_comb begin
		for (int l = 0; l < NL; l++) quo[l] = quo_s[QW-1][l];
	end

endmodule

### hdl/uvs_qsin.sv
// ----------------------------------------------------------------------------
// uvs_qsin
// Quarter-wave sine, several lanes, seven stages: square, four Horner
// steps of the odd polynomial, final product, rounding to Q1.15.
// ----------------------------------------------------------------------------
module uvs_qsin #(
	parameter int unsigned NL = 4,
	parameter int unsigned TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          vin,
	input  logic [16:0]   arg [NL],
	input  logic [TW-1:0] tag_in,
	output logic          vout,
	output logic [15:0]   mag [NL],
	output logic [TW-1:0] tag_out
);

	localparam int unsigned NS = 7;
	localparam int unsigned QUARTER_LIM = uvs_pkg::QUARTER_TURN;

	logic          v_s   [NS];
	logic [TW-1:0] tag_s [NS];
	logic [16:0]   arg_s [5][NL];
	logic [30:0]   t2_s  [4][NL];
	logic [30:0]   acc_s [5][NL];
	logic [31:0]   s_s6  [NL];
	logic [15:0]   mag_s7 [NL];

	logic [16:0] arg_c   [NL];
	logic [33:0] sq      [NL];
	logic [61:0] hprod   [4][NL];
	logic [47:0] fprod   [NL];
	logic [32:0] rnd     [NL];

	always_comb begin
		for (int l = 0; l < NL; l++) begin
			arg_c[l] = (arg[l] > 17'(QUARTER_LIM)) ? 17'(QUARTER_LIM) : arg[l];
			sq[l]    = 34'(arg_c[l]) * 34'(arg_c[l]);
			for (int h = 0; h < 4; h++) begin
				hprod[h][l] = 62'(t2_s[h][l]) * 62'(acc_s[h][l]);
			end
			fprod[l] = 48'(arg_s[4][l]) * 48'(acc_s[4][l]);
			rnd[l]   = 33'(s_s6[l]) + 33'(uvs_pkg::SIN_ROUND);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NS; g++) v_s[g] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= vin;
			for (int g = 1; g < NS; g++) v_s[g] <= v_s[g-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s[0] <= tag_in;
			for (int g = 1; g < NS; g++) tag_s[g] <= tag_s[g-1];
			for (int l = 0; l < NL; l++) begin
				// t2 = (t*t)>>30 with t = arg<<14
				arg_s[0][l] <= arg_c[l];
				t2_s[0][l]  <= sq[l][32:2];
				acc_s[0][l] <= uvs_pkg::C9;
				for (int h = 1; h < 5; h++) begin
					arg_s[h][l] <= arg_s[h-1][l];
					acc_s[h][l] <= uvs_pkg::HORNER_C[h-1] - hprod[h-1][l][60:30];
				end
				for (int h = 1; h < 4; h++) t2_s[h][l] <= t2_s[h-1][l];
				// (t*acc)>>30 is (arg*acc)>>16
				s_s6[l] <= fprod[l][47:16];
				mag_s7[l] <= (rnd[l][32:15] > 18'(uvs_pkg::SIN_MAX)) ?
					uvs_pkg::SIN_MAX : rnd[l][30:15];
			end
		end
	end

	assign vout    = v_s[NS-1];
	assign tag_out = tag_s[NS-1];
	always_comb begin
		for (int l = 0; l < NL; l++) mag[l] = mag_s7[l];
	end

endmodule

### hdl/uv_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_core
// Vertex, texture coordinate and quad index generator for a UV sphere grid.
//
//   channel  | dir | handshake       | word
//   ---------+-----+-----------------+------------------------------------
//   point    | in  | valid/ready     | col, row
//   vertex   | out | valid/ready     | pos xyz, tex uv, four indices, flags
//   apb      | in  | psel/penable    | radius, col and row fragment counts
//
// One point per cycle sustained while the vertex channel is not stalled; the pipe holds an
// input stage, a 19-stage divider (one quotient bit per stage), a 7-stage sine unit and three
// scaling stages, the last of which is the output register.
// All stages move together; a stalled vertex holds the whole pipe and the
// point channel is ready whenever the output register is empty or taken.
// Reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_core #(
	parameter int unsigned MAX_FRAGMENTS = uvs_pkg::MAX_FRAGMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [uvs_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	uvs_point_if.sink                  point,
	uvs_vertex_if.source               vertex
);

	localparam int unsigned DW = $clog2(MAX_FRAGMENTS + 1);
	localparam int unsigned QW = uvs_pkg::DIV_QW;
	localparam int unsigned NW = DW + QW;
	localparam int unsigned CW = ((DW > 8) ? DW : 8) + 1;
	localparam int unsigned NL = uvs_pkg::NLANE;

	// configuration registers
	logic [15:0] radius_q;
	logic [7:0]  col_fragments_q;
	logic [7:0]  row_fragments_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q        <= uvs_pkg::RADIUS_RST;
			col_fragments_q <= uvs_pkg::COLS_RST;
			row_fragments_q <= uvs_pkg::ROWS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (uvs_pkg::reg_idx_t'(paddr[3:2]))
				uvs_pkg::REG_RADIUS: radius_q        <= pwdata[15:0];
				uvs_pkg::REG_COLS:   col_fragments_q <= pwdata[7:0];
				uvs_pkg::REG_ROWS:   row_fragments_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (uvs_pkg::reg_idx_t'(paddr[3:2]))
			uvs_pkg::REG_RADIUS: prdata = {16'd0, radius_q};
			uvs_pkg::REG_COLS:   prdata = {24'd0, col_fragments_q};
			uvs_pkg::REG_ROWS:   prdata = {24'd0, row_fragments_q};
			default:             prdata = 32'd0;
		endcase
	end

	// pipeline advance
	logic adv;
	assign adv         = !vertex.valid || vertex.ready;
	assign point.ready = adv;

	// fragment counts saturate at the supported maximum
	logic [DW-1:0] cols, rows;
	assign cols = (32'(col_fragments_q) > 32'(MAX_FRAGMENTS)) ?
		DW'(MAX_FRAGMENTS) : DW'(col_fragments_q);
	assign rows = (32'(row_fragments_q) > 32'(MAX_FRAGMENTS)) ?
		DW'(MAX_FRAGMENTS) : DW'(row_fragments_q);

	// ---- stage 1: grid test, indices, divider numerators
	logic [CW-1:0] col_x, row_x, cols_x, rows_x, w;
	logic [31:0]   tl;
	logic          in_grid_c, has_cell_c;
	uvs_pkg::grid_t grid_c;
	logic [NW-1:0] num_c [NL];

	always_comb begin
		col_x  = CW'(point.col);
		row_x  = CW'(point.row);
		cols_x = CW'(cols);
		rows_x = CW'(rows);
		w      = cols_x + CW'(1);
		tl     = 32'(point.row) * 32'(w) + 32'(point.col);
		in_grid_c  = (cols != '0) && (rows != '0) && (col_x <= cols_x) &&
			(row_x <= rows_x);
		has_cell_c = in_grid_c && (col_x < cols_x) && (row_x < rows_x);
		grid_c.in_grid  = in_grid_c;
		grid_c.has_cell = has_cell_c;
		grid_c.idx_tl   = tl[15:0];
		grid_c.idx_bl   = has_cell_c ? 16'(tl + 32'(w)) : 16'd0;
		grid_c.idx_br   = has_cell_c ? 16'(tl + 32'(w) + 32'd1) : 16'd0;
		grid_c.idx_tr   = has_cell_c ? 16'(tl + 32'd1) : 16'd0;
		// half-up rounding: add half the divisor
		num_c[0] = (NW'(point.col) << uvs_pkg::SH_FULL) + NW'(cols >> 1);
		num_c[1] = (NW'(point.row) << uvs_pkg::SH_HALF) + NW'(rows >> 1);
		num_c[2] = (NW'(point.col) << uvs_pkg::SH_TEX) + NW'(cols >> 1);
		num_c[3] = (NW'(point.row) << uvs_pkg::SH_TEX) + NW'(rows >> 1);
	end

	logic           v_s1;
	uvs_pkg::grid_t grid_s1;
	logic [NW-1:0]  num_s1 [NL];
	logic [DW-1:0]  den [NL];

	assign den[0] = cols;
	assign den[1] = rows;
	assign den[2] = cols;
	assign den[3] = rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= point.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grid_s1 <= grid_c;
			for (int l = 0; l < NL; l++) num_s1[l] <= num_c[l];
		end
	end

	// ---- divider
	logic           v_dv;
	uvs_pkg::grid_t grid_dv;
	logic [QW-1:0]  quo [NL];

	uvs_div #(
		.NL(NL),
		.DW(DW),
		.QW(QW),
		.TW($bits(uvs_pkg::grid_t))
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (v_s1),
		.num    (num_s1),
		.den    (den),
		.tag_in (grid_s1),
		.vout   (v_dv),
		.quo    (quo),
		.tag_out(grid_dv)
	);

	// phases in quarter turns; lanes are sin lon, cos lon, sin lat, cos lat
	logic [17:0] ph [NL];
	logic [16:0] sarg [NL];
	uvs_pkg::vtx_meta_t meta_c;

	always_comb begin
		ph[0] = quo[0][17:0];
		ph[1] = quo[0][17:0] + 18'(uvs_pkg::QUARTER_TURN);
		ph[2] = quo[1][17:0];
		ph[3] = quo[1][17:0] + 18'(uvs_pkg::QUARTER_TURN);
		meta_c.grid  = grid_dv;
		meta_c.tex_u = quo[2][16:0];
		meta_c.tex_v = quo[3][16:0];
		for (int l = 0; l < NL; l++) begin
			// odd quadrants mirror the quarter wave
			sarg[l] = ph[l][16] ? 17'(uvs_pkg::QUARTER_TURN) - 17'(ph[l][15:0]) :
				17'(ph[l][15:0]);
			meta_c.neg[l] = ph[l][17];
		end
	end

	// ---- sine unit
	logic               v_sn;
	uvs_pkg::vtx_meta_t meta_sn;
	logic [15:0]        mag [NL];

	uvs_qsin #(
		.NL(NL),
		.TW($bits(uvs_pkg::vtx_meta_t))
	) u_qsin (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vin    (v_dv),
		.arg    (sarg),
		.tag_in (meta_c),
		.vout   (v_sn),
		.mag    (mag),
		.tag_out(meta_sn)
	);

	// ---- stage 2: magnitude products
	logic               v_s2;
	uvs_pkg::vtx_meta_t meta_s2;
	logic [31:0]        m_x_s2, m_z_s2, m_y_s2;

	// ---- stage 3: radius scaling
	logic               v_s3;
	uvs_pkg::vtx_meta_t meta_s3;
	logic [47:0]        m_x_s3, m_z_s3;
	logic [16:0]        y_mag_s3;
	logic [32:0]        y_sum;

	// ---- stage 4: rounding, sign, output register
	logic               v_s4;
	logic [46:0]        x_sum, z_sum;
	logic [16:0]        x_mag, z_mag;
	logic               neg_x, neg_y, neg_z;

	assign y_sum = 33'(m_y_s2) + 33'(uvs_pkg::SIN_ROUND);
	assign x_sum = 47'(m_x_s3) + (47'(1) << 29);
	assign z_sum = 47'(m_z_s3) + (47'(1) << 29);
	assign x_mag = x_sum[46:30];
	assign z_mag = z_sum[46:30];
	assign neg_x = meta_s3.neg[1] ^ meta_s3.neg[2];
	assign neg_z = meta_s3.neg[0] ^ meta_s3.neg[2];
	assign neg_y = meta_s3.neg[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_sn;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta_sn;
			m_x_s2  <= 32'(mag[1]) * 32'(mag[2]);
			m_z_s2  <= 32'(mag[0]) * 32'(mag[2]);
			m_y_s2  <= 32'(radius_q) * 32'(mag[3]);

			meta_s3  <= meta_s2;
			m_x_s3   <= 48'(radius_q) * 48'(m_x_s2);
			m_z_s3   <= 48'(radius_q) * 48'(m_z_s2);
			y_mag_s3 <= y_sum[31:15];

			if (meta_s3.grid.in_grid) begin
				vertex.pos_x            <= neg_x ? -$signed(x_mag) : $signed(x_mag);
				vertex.pos_y            <= neg_y ? -$signed(y_mag_s3) : $signed(y_mag_s3);
				vertex.pos_z            <= neg_z ? -$signed(z_mag) : $signed(z_mag);
				vertex.tex_u            <= meta_s3.tex_u;
				vertex.tex_v            <= meta_s3.tex_v;
				vertex.idx_top_left     <= meta_s3.grid.idx_tl;
				vertex.idx_bottom_left  <= meta_s3.grid.idx_bl;
				vertex.idx_bottom_right <= meta_s3.grid.idx_br;
				vertex.idx_top_right    <= meta_s3.grid.idx_tr;
				vertex.has_cell         <= meta_s3.grid.has_cell;
				vertex.in_grid          <= 1'b1;
			end else begin
				vertex.pos_x            <= '0;
				vertex.pos_y            <= '0;
				vertex.pos_z            <= '0;
				vertex.tex_u            <= '0;
				vertex.tex_v            <= '0;
				vertex.idx_top_left     <= '0;
				vertex.idx_bottom_left  <= '0;
				vertex.idx_bottom_right <= '0;
				vertex.idx_top_right    <= '0;
				vertex.has_cell         <= 1'b0;
				vertex.in_grid          <= 1'b0;
			end
		end
	end

	assign vertex.valid = v_s4;

`ifndef NO_ASSERTIONS
	a_off_grid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && !vertex.in_grid |-> vertex.pos_x == 0 &&
		vertex.pos_y == 0 && vertex.pos_z == 0 && vertex.tex_u == 0 &&
		vertex.tex_v == 0 && vertex.idx_top_left == 0)
		else $error("off-grid vertex carries nonzero fields");

	a_cell_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.has_cell |-> vertex.in_grid)
		else $error("cell flagged outside the grid");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.in_grid |-> vertex.tex_u <= 17'd65536 &&
		vertex.tex_v <= 17'd65536)
		else $error("texture coordinate above one");

	a_cell_right: assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid && vertex.has_cell |->
		vertex.idx_top_right == 16'(vertex.idx_top_left + 16'd1) &&
		vertex.idx_bottom_right == 16'(vertex.idx_bottom_left + 16'd1))
		else $error("right corner index does not follow left corner");
`endif

endmodule
